// File: rtl/turtle_command_interpreter_unit_defines.svh
// Assertion macros for the turtle command interpreter.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef TURTLE_COMMAND_INTERPRETER_UNIT_DEFINES_SVH
`define TURTLE_COMMAND_INTERPRETER_UNIT_DEFINES_SVH

// Implication checked in the same cycle.
`define TCI_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tci: same-cycle check failed");

// Implication checked in the next cycle.
`define TCI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tci: next-cycle check failed");

`endif

// File: rtl/tci_pkg.sv
// Shared types, constants and trig table for the turtle command interpreter.
// No dependencies; used by tci_motion, tci_stack and the top level.
package tci_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int COORD_W    = 32;
    localparam int HEAD_W     = 9;
    localparam int CMD_W      = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    // command characters
    localparam logic [CMD_W-1:0] CMD_FWD_F    = 8'h46; // F
    localparam logic [CMD_W-1:0] CMD_FWD_G    = 8'h47; // G
    localparam logic [CMD_W-1:0] CMD_TURN_POS = 8'h2B; // +
    localparam logic [CMD_W-1:0] CMD_TURN_NEG = 8'h2D; // -
    localparam logic [CMD_W-1:0] CMD_SHRINK   = 8'h3C; // <
    localparam logic [CMD_W-1:0] CMD_PUSH     = 8'h5B; // [
    localparam logic [CMD_W-1:0] CMD_POP      = 8'h5D; // ]

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_ANGLE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_HEADING = 1'b1;

    localparam logic [HEAD_W-1:0] TURN_RESET  = 9'd90;
    localparam logic [HEAD_W-1:0] START_RESET = 9'd0;

    localparam logic [HEAD_W-1:0] DEG_QUARTER  = 9'd90;
    localparam logic [HEAD_W-1:0] DEG_HALF     = 9'd180;
    localparam logic [HEAD_W-1:0] DEG_3QUARTER = 9'd270;
    localparam logic [HEAD_W-1:0] DEG_FULL     = 9'd360;

    localparam int SHRINK_Q16   = 43909;  // 0.67 in Q0.16
    localparam int SHRINK_ROUND = 32768;
    localparam int SCALE_ROUND  = 16384;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    typedef enum logic [1:0] {
        FAULT_NONE      = 2'd0,
        FAULT_PUSH_FULL = 2'd1,
        FAULT_POP_EMPTY = 2'd2
    } t_fault;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             first;
    } t_cmd_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] seg_start_x;
        logic signed [COORD_W-1:0] seg_start_y;
        logic signed [COORD_W-1:0] seg_end_x;
        logic signed [COORD_W-1:0] seg_end_y;
        t_fault                    fault;
    } t_seg_out;

    typedef struct packed {
        logic home;   // stack emptied before the command
        logic push;
        logic pop;
    } t_stk_ctl;

    typedef struct packed {
        logic empty;
        logic full;
    } t_stk_status;

    // Quarter-wave sine in Q1.15, 1.0 kept as 32768. Built at elaboration
    // from an eight-term Taylor series evaluated in Q30.
    typedef logic [15:0] t_qsin_tab [0:90];

    function automatic t_qsin_tab f_build_qsin();
        t_qsin_tab   tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] q;
        longint      s;
        for (int d = 0; d <= 90; d++) begin
            x  = 64'(d) * PI_Q30 / 64'd180;
            x2 = (x * x) >> 30;
            t  = x;
            s  = longint'(x);
            for (int k = 1; k <= 7; k++) begin
                t = ((t * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
                if (k[0]) begin
                    s = s - longint'(t);
                end else begin
                    s = s + longint'(t);
                end
            end
            if (s < 0) begin
                s = 0;
            end
            q = (64'(s) + 64'd16384) >> 15;
            if (q > 64'd32768) begin
                q = 64'd32768;
            end
            tab[d] = q[15:0];
        end
        return tab;
    endfunction

    localparam t_qsin_tab QSIN = f_build_qsin();

    // v is at most 511, so one conditional subtract is enough
    function automatic logic [HEAD_W-1:0] f_mod360(input logic [HEAD_W-1:0] v);
        return (v >= DEG_FULL) ? HEAD_W'(v - DEG_FULL) : v;
    endfunction

    // h in 0..359
    function automatic logic signed [16:0] f_sin(input logic [HEAD_W-1:0] h);
        logic [HEAD_W-1:0] idx;
        logic              neg;
        logic [15:0]       mag;
        if (h <= DEG_QUARTER) begin
            idx = h;
            neg = 1'b0;
        end else if (h <= DEG_HALF) begin
            idx = DEG_HALF - h;
            neg = 1'b0;
        end else if (h <= DEG_3QUARTER) begin
            idx = h - DEG_HALF;
            neg = 1'b1;
        end else begin
            idx = DEG_FULL - h;
            neg = 1'b1;
        end
        mag = QSIN[idx[6:0]];
        return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    function automatic logic signed [16:0] f_cos(input logic [HEAD_W-1:0] h);
        return f_sin(f_mod360(h + DEG_QUARTER));
    endfunction

endpackage

// File: rtl/turtle_command_interpreter_unit.sv
// Turtle command interpreter: takes one L-system command word per cycle
// (F/G move, +/- turn, < shrink, [ push, ] pop, others ignored) and returns a
// segment word for each move or a fault word for a push on a full stack or a
// pop on an empty one. Sustained rate is one command per cycle unless a held
// result stalls on i_ready; results are registered in r_out. The rate is set
// by the turtle state loop, which does one saturating add or one turn add per
// cycle while tci_motion registers the step vector (table lookup and multiply)
// for the state the turtle will have next. The save stack needs no clearing
// pass after reset. Configuration writes are taken every cycle. Uses tci_pkg,
// tci_stack, tci_motion and the assertion macro header.

`include "turtle_command_interpreter_unit_defines.svh"

module turtle_command_interpreter_unit #(
    parameter int STACK_DEPTH = tci_pkg::STACK_DEPTH_DEF,
    parameter int FRAC_BITS   = tci_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  tci_pkg::t_cmd_in                    i_data,
    output logic                                o_valid,
    input  logic                                i_ready,
    output tci_pkg::t_seg_out                   o_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tci_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tci_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int CW     = tci_pkg::COORD_W;
    localparam int HW     = tci_pkg::HEAD_W;
    localparam int SW     = FRAC_BITS + 1;
    localparam int DW     = FRAC_BITS + 2;
    localparam int WORD_W = 2 * CW + HW + SW;
    localparam logic [SW-1:0] STEP_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    function automatic logic signed [CW-1:0] f_sat_add(input logic signed [CW-1:0] a,
                                                       input logic signed [DW-1:0] d);
        logic signed [CW:0] s;
        s = {a[CW-1], a} + {{(CW+1-DW){d[DW-1]}}, d};
        if (s[CW] != s[CW-1]) begin
            return s[CW] ? tci_pkg::COORD_MIN : tci_pkg::COORD_MAX;
        end
        return s[CW-1:0];
    endfunction

    // input stage
    logic             r_in_valid;
    tci_pkg::t_cmd_in r_in;
    // result stage
    logic              r_out_valid;
    tci_pkg::t_seg_out r_out;
    tci_pkg::t_seg_out n_out;
    // turtle state
    logic signed [CW-1:0] r_pos_x, r_pos_y, n_pos_x, n_pos_y;
    logic [HW-1:0]        r_heading, n_heading;
    logic [SW-1:0]        r_step, n_step;
    // configuration, kept reduced modulo 360
    logic [HW-1:0] r_turn;
    logic [HW-1:0] r_home_heading;
    logic [HW-1:0] n_home_heading;

    logic                 fire;
    logic                 home;
    logic                 emit;
    logic signed [CW-1:0] cur_x, cur_y, end_x, end_y;
    logic [HW-1:0]        cur_heading, heading_pos, heading_neg;
    logic [HW:0]          sum_pos, sum_neg;
    logic [SW-1:0]        cur_step, cur_shrunk;
    logic signed [DW-1:0] cur_dx, cur_dy;
    logic                 stk_empty, stk_full;

    logic signed [DW-1:0] dx, dy, home_dx, home_dy;
    logic [SW-1:0]        shrunk, home_shrunk;

    tci_pkg::t_stk_ctl    stk_ctl;
    tci_pkg::t_stk_status stk_status;
    logic [WORD_W-1:0]    stk_top;
    logic [WORD_W-1:0]    push_word;
    logic signed [CW-1:0] top_x, top_y;
    logic [HW-1:0]        top_heading;
    logic [SW-1:0]        top_step;

    // a command retires when the result slot is free, whether or not it has a result
    assign fire        = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready     = !r_in_valid || fire;
    assign o_valid     = r_out_valid;
    assign o_data      = r_out;
    assign o_cfg_ready = 1'b1;

    // next start heading feeds the home step vector so both move together
    always_comb begin
        if (!i_rst_n) begin
            n_home_heading = tci_pkg::START_RESET;
        end else if (i_cfg_valid && (i_cfg_index == tci_pkg::CFG_START_HEADING)) begin
            n_home_heading = tci_pkg::f_mod360(i_cfg_data);
        end else begin
            n_home_heading = r_home_heading;
        end
    end

    always_ff @(posedge i_clk) begin
        r_home_heading <= n_home_heading;
        if (!i_rst_n) begin
            r_turn <= tci_pkg::TURN_RESET;
        end else if (i_cfg_valid && (i_cfg_index == tci_pkg::CFG_TURN_ANGLE)) begin
            r_turn <= tci_pkg::f_mod360(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_data;
        end
    end

    assign top_x       = stk_top[WORD_W-1 -: CW];
    assign top_y       = stk_top[WORD_W-CW-1 -: CW];
    assign top_heading = stk_top[SW+HW-1 -: HW];
    assign top_step    = stk_top[SW-1:0];

    always_comb begin
        home        = r_in.first;
        cur_x       = home ? '0 : r_pos_x;
        cur_y       = home ? '0 : r_pos_y;
        cur_heading = home ? r_home_heading : r_heading;
        cur_step    = home ? STEP_ONE : r_step;
        cur_dx      = home ? home_dx : dx;
        cur_dy      = home ? home_dy : dy;
        cur_shrunk  = home ? home_shrunk : shrunk;
        stk_empty   = home || stk_status.empty;
        stk_full    = !home && stk_status.full;

        end_x = f_sat_add(cur_x, cur_dx);
        end_y = f_sat_add(cur_y, cur_dy);

        sum_pos     = {1'b0, cur_heading} + {1'b0, r_turn};
        sum_neg     = {1'b0, cur_heading} + ({1'b0, tci_pkg::DEG_FULL} - {1'b0, r_turn});
        heading_pos = (sum_pos >= {1'b0, tci_pkg::DEG_FULL})
                    ? HW'(sum_pos - {1'b0, tci_pkg::DEG_FULL}) : sum_pos[HW-1:0];
        heading_neg = (sum_neg >= {1'b0, tci_pkg::DEG_FULL})
                    ? HW'(sum_neg - {1'b0, tci_pkg::DEG_FULL}) : sum_neg[HW-1:0];

        push_word = {cur_x, cur_y, cur_heading, cur_step};

        n_pos_x   = r_pos_x;
        n_pos_y   = r_pos_y;
        n_heading = r_heading;
        n_step    = r_step;
        stk_ctl   = '0;
        emit      = 1'b0;
        n_out     = '0;
        n_out.fault = tci_pkg::FAULT_NONE;

        if (fire) begin
            n_pos_x      = cur_x;
            n_pos_y      = cur_y;
            n_heading    = cur_heading;
            n_step       = cur_step;
            stk_ctl.home = home;
            unique case (r_in.cmd) inside
                tci_pkg::CMD_FWD_F, tci_pkg::CMD_FWD_G: begin
                    n_pos_x           = end_x;
                    n_pos_y           = end_y;
                    emit              = 1'b1;
                    n_out.seg_start_x = cur_x;
                    n_out.seg_start_y = cur_y;
                    n_out.seg_end_x   = end_x;
                    n_out.seg_end_y   = end_y;
                end
                tci_pkg::CMD_SHRINK: begin
                    n_step = cur_shrunk;
                end
                tci_pkg::CMD_TURN_POS: begin
                    n_heading = heading_pos;
                end
                tci_pkg::CMD_TURN_NEG: begin
                    n_heading = heading_neg;
                end
                tci_pkg::CMD_PUSH: begin
                    if (stk_full) begin
                        emit        = 1'b1;
                        n_out.fault = tci_pkg::FAULT_PUSH_FULL;
                    end else begin
                        stk_ctl.push = 1'b1;
                    end
                end
                tci_pkg::CMD_POP: begin
                    if (stk_empty) begin
                        emit        = 1'b1;
                        n_out.fault = tci_pkg::FAULT_POP_EMPTY;
                    end else begin
                        stk_ctl.pop = 1'b1;
                        n_pos_x     = top_x;
                        n_pos_y     = top_y;
                        n_heading   = top_heading;
                        n_step      = top_step;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_heading <= tci_pkg::f_mod360(tci_pkg::START_RESET);
            r_step    <= STEP_ONE;
        end else begin
            r_pos_x   <= n_pos_x;
            r_pos_y   <= n_pos_y;
            r_heading <= n_heading;
            r_step    <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit) begin
            r_out <= n_out;
        end
    end

    tci_motion #(
        .FRAC_BITS(FRAC_BITS)
    ) u_motion (
        .i_clk          (i_clk),
        .i_heading      (n_heading),
        .i_step         (n_step),
        .i_home_heading (n_home_heading),
        .o_dx           (dx),
        .o_dy           (dy),
        .o_home_dx      (home_dx),
        .o_home_dy      (home_dy),
        .o_shrunk       (shrunk),
        .o_home_shrunk  (home_shrunk)
    );

    tci_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .WORD_W      (WORD_W)
    ) u_stack (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (stk_ctl),
        .i_word   (push_word),
        .o_top    (stk_top),
        .o_status (stk_status)
    );

    // fault words carry no coordinates
    `TCI_ASSERT_NOW(a_fault_no_coords, o_valid && (o_data.fault != tci_pkg::FAULT_NONE), (o_data.seg_start_x == '0) && (o_data.seg_start_y == '0) && (o_data.seg_end_x == '0) && (o_data.seg_end_y == '0))
    // a move leaves the turtle at the end point it reports
    `TCI_ASSERT_NEXT(a_move_sets_pos, fire && emit && (n_out.fault == tci_pkg::FAULT_NONE), o_valid && (r_pos_x == o_data.seg_end_x) && (r_pos_y == o_data.seg_end_y))
    // a push that was taken leaves at least one saved entry
    `TCI_ASSERT_NEXT(a_push_nonempty, fire && stk_ctl.push, !stk_status.empty)
    `TCI_ASSERT_NOW(a_heading_range, 1'b1, r_heading < tci_pkg::DEG_FULL)

endmodule

// File: rtl/tci_stack.sv
// Save stack for the turtle: top entry and the one below it in registers,
// deeper entries in a single-port-write, registered-read memory. Uses tci_pkg.
module tci_stack #(
    parameter int STACK_DEPTH = tci_pkg::STACK_DEPTH_DEF,
    parameter int WORD_W      = 90
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tci_pkg::t_stk_ctl     i_ctl,
    input  logic [WORD_W-1:0]     i_word,
    output logic [WORD_W-1:0]     o_top,
    output tci_pkg::t_stk_status  o_status
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int LW = $clog2(STACK_DEPTH + 1);
    localparam logic [LW-1:0] LEVEL_FULL = LW'(STACK_DEPTH);

    logic [LW-1:0]     r_level;
    logic [LW-1:0]     n_level;
    logic [LW-1:0]     lvl_eff;
    logic [LW-1:0]     wr_lvl;
    logic [LW-1:0]     rd_lvl;
    logic [WORD_W-1:0] r_top;
    logic [WORD_W-1:0] r_below;
    logic [WORD_W-1:0] mem [0:STACK_DEPTH-1];

    // Entry k of the stack lives at mem[k] for k < level-1; entry level-1 is
    // r_top and entry level-2 is mirrored in r_below so a pop needs no wait.
    always_comb begin
        lvl_eff = i_ctl.home ? '0 : r_level;
        wr_lvl  = lvl_eff - LW'(1);
        rd_lvl  = lvl_eff - LW'(3);
        if (i_ctl.push) begin
            n_level = lvl_eff + LW'(1);
        end else if (i_ctl.pop) begin
            n_level = lvl_eff - LW'(1);
        end else begin
            n_level = lvl_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else begin
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push && (lvl_eff != '0)) begin
            mem[wr_lvl[AW-1:0]] <= r_top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_top   <= i_word;
            r_below <= r_top;
        end else if (i_ctl.pop) begin
            r_top   <= r_below;
            r_below <= mem[rd_lvl[AW-1:0]];
        end
    end

    assign o_top          = r_top;
    assign o_status.empty = (r_level == '0);
    assign o_status.full  = (r_level == LEVEL_FULL);

endmodule

// File: rtl/tci_motion.sv
// Step vector and shrink precompute: registers step*cos, step*sin and the
// shrunk step for the turtle state of the next cycle. Uses tci_pkg.
module tci_motion #(
    parameter int FRAC_BITS = tci_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic [tci_pkg::HEAD_W-1:0]          i_heading,
    input  logic [FRAC_BITS:0]                  i_step,
    input  logic [tci_pkg::HEAD_W-1:0]          i_home_heading,
    output logic signed [FRAC_BITS+1:0]         o_dx,
    output logic signed [FRAC_BITS+1:0]         o_dy,
    output logic signed [FRAC_BITS+1:0]         o_home_dx,
    output logic signed [FRAC_BITS+1:0]         o_home_dy,
    output logic [FRAC_BITS:0]                  o_shrunk,
    output logic [FRAC_BITS:0]                  o_home_shrunk
);

    localparam int SW = FRAC_BITS + 1;
    localparam int DW = FRAC_BITS + 2;
    localparam logic [SW-1:0] STEP_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // step * c / 2^15, magnitude rounded half up, sign restored
    function automatic logic signed [DW-1:0] f_scale(input logic [SW-1:0] step,
                                                     input logic signed [16:0] c);
        logic [16:0]    c_abs;
        logic [SW+16:0] prod;
        logic [SW-1:0]  mag;
        c_abs = c[16] ? 17'(-c) : 17'(c);
        prod  = (SW+17)'(step) * (SW+17)'(c_abs[15:0]) + (SW+17)'(tci_pkg::SCALE_ROUND);
        mag   = prod[SW+14:15];
        return c[16] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    function automatic logic [SW-1:0] f_shrink(input logic [SW-1:0] step);
        logic [SW+16:0] acc;
        acc = (SW+17)'(step) * (SW+17)'(tci_pkg::SHRINK_Q16)
            + (SW+17)'(tci_pkg::SHRINK_ROUND);
        return acc[SW+15:16];
    endfunction

    logic signed [DW-1:0] r_dx;
    logic signed [DW-1:0] r_dy;
    logic signed [DW-1:0] r_home_dx;
    logic signed [DW-1:0] r_home_dy;
    logic [SW-1:0]        r_shrunk;

    always_ff @(posedge i_clk) begin
        r_dx      <= f_scale(i_step, tci_pkg::f_cos(i_heading));
        r_dy      <= f_scale(i_step, tci_pkg::f_sin(i_heading));
        r_shrunk  <= f_shrink(i_step);
        r_home_dx <= f_scale(STEP_ONE, tci_pkg::f_cos(i_home_heading));
        r_home_dy <= f_scale(STEP_ONE, tci_pkg::f_sin(i_home_heading));
    end

    assign o_dx          = r_dx;
    assign o_dy          = r_dy;
    assign o_home_dx     = r_home_dx;
    assign o_home_dy     = r_home_dy;
    assign o_shrunk      = r_shrunk;
    assign o_home_shrunk = f_shrink(STEP_ONE);

endmodule
